FILE: rtl/bihc_pkg.sv
// Shared types and constants for the boot image header checker.
// Holds the transfer structs, the verdict codes and the slot geometry.
// Used by bihc_track, bihc_verdict and boot_image_header_checker.
package bihc_pkg;

  // Slot geometry.
  localparam int SLOT_BYTES   = 16384;
  localparam int SLOT_WORDS   = SLOT_BYTES / 4;
  localparam int WORD_IDX_W   = $clog2(SLOT_WORDS + 1);
  localparam int STOP_IDX_W   = $clog2(SLOT_WORDS);

  // Header layout: preamble, load command, then the configuration words.
  localparam int CFG_BYTES    = 128;
  localparam int CFG_END_WORD = 2 + CFG_BYTES / 4;

  // Reserved word patterns.
  localparam logic [31:0] PREAMBLE_WORD = 32'hAA55_AA55;
  localparam logic [31:0] LOAD_CKSUM    = 32'h8010_0000;
  localparam logic [31:0] LOAD_NOCKSUM  = 32'h8011_0000;
  localparam logic [31:0] TERM_STOP     = 32'h80FF_0000;
  localparam logic [31:0] TERM_CRCSTOP  = 32'h808F_0000;

  // Output field widths.
  localparam int TERM_OFF_W   = 14;
  localparam int LEN_W        = 15;

  typedef enum logic [1:0] {
    LOAD_BAD    = 2'd0,
    LOAD_WITH   = 2'd1,
    LOAD_NO_SUM = 2'd2
  } load_kind_t;

  typedef enum logic [1:0] {
    CK_NOT_CHECKED = 2'd0,
    CK_PASS        = 2'd1,
    CK_FAIL        = 2'd2,
    CK_SKIPPED     = 2'd3
  } cksum_status_t;

  typedef enum logic [1:0] {
    TERM_NOT_SEARCHED = 2'd0,
    TERM_NONE_FOUND   = 2'd1,
    TERM_IS_STOP      = 2'd2,
    TERM_IS_CRCSTOP   = 2'd3
  } term_kind_t;

  typedef enum logic [1:0] {
    LIVE_NOT_COMPARED = 2'd0,
    LIVE_EQUAL        = 2'd1,
    LIVE_DIFFER       = 2'd2
  } live_match_t;

  // One input transfer.
  typedef struct packed {
    logic [31:0] slot_word;
    logic [31:0] live_word;
    logic        last;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic                  slot_too_short;
    logic                  preamble_ok;
    load_kind_t            load_kind;
    logic                  config_present;
    cksum_status_t         checksum_status;
    logic [31:0]           computed_sum;
    term_kind_t            terminator_kind;
    logic [TERM_OFF_W-1:0] terminator_offset;
    logic [LEN_W-1:0]      image_length;
    logic [LEN_W-1:0]      command_bytes;
    live_match_t           live_match;
    logic                  check_failed;
  } out_item_t;

  // Stream state after the current word has been folded in.
  typedef struct packed {
    logic [WORD_IDX_W-1:0] word_count;
    logic [31:0]           running_sum;
    logic                  preamble_ok;
    load_kind_t            load_code;
    cksum_status_t         checksum_result;
    term_kind_t            stop_kind;
    logic [STOP_IDX_W-1:0] stop_word_index;
    logic                  live_mismatch;
  } track_t;

endpackage

FILE: rtl/bihc_track.sv
// Stream state of the boot image header checker: word count, sum,
// header decode, terminator search and live compare flag.
// Depends on bihc_pkg.
module bihc_track
  import bihc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  in_item_t item,
  input  logic     live_enable,
  output track_t   view
);

  logic [WORD_IDX_W-1:0] word_index;
  logic [31:0]           running_sum;
  logic                  preamble_seen_ok;
  load_kind_t            load_code;
  cksum_status_t         checksum_result;
  term_kind_t            stop_kind;
  logic [STOP_IDX_W-1:0] stop_word_index;
  logic                  live_mismatch;

  logic [WORD_IDX_W-1:0] idx;
  logic                  in_slot;
  logic [WORD_IDX_W-1:0] scan_first;
  logic [31:0]           w;

  assign idx        = word_index;
  assign w          = item.slot_word;
  assign in_slot    = word_index < WORD_IDX_W'(SLOT_WORDS);
  assign scan_first = (load_code == LOAD_WITH) ? WORD_IDX_W'(CFG_END_WORD + 1)
                                               : WORD_IDX_W'(CFG_END_WORD);

  // Fold the current word into a copy of the stream state.
  always_comb begin
    view.word_count      = word_index;
    view.running_sum     = running_sum;
    view.preamble_ok     = preamble_seen_ok;
    view.load_code       = load_code;
    view.checksum_result = checksum_result;
    view.stop_kind       = stop_kind;
    view.stop_word_index = stop_word_index;
    view.live_mismatch   = live_mismatch;
    if (in_slot) begin
      view.word_count = word_index + WORD_IDX_W'(1);
      if (idx < WORD_IDX_W'(CFG_END_WORD)) begin
        view.running_sum = running_sum + w;
      end
      if (idx == WORD_IDX_W'(0)) begin
        view.preamble_ok = (w == PREAMBLE_WORD);
      end
      if (idx == WORD_IDX_W'(1)) begin
        if (w == LOAD_CKSUM) begin
          view.load_code = LOAD_WITH;
        end else if (w == LOAD_NOCKSUM) begin
          view.load_code = LOAD_NO_SUM;
        end else begin
          view.load_code = LOAD_BAD;
        end
      end
      if (idx >= WORD_IDX_W'(2) && idx < WORD_IDX_W'(CFG_END_WORD) &&
          live_enable && (w != item.live_word)) begin
        view.live_mismatch = 1'b1;
      end
      if (idx == WORD_IDX_W'(CFG_END_WORD) && load_code == LOAD_WITH) begin
        view.checksum_result = (running_sum == w) ? CK_PASS : CK_FAIL;
      end
      if (idx >= scan_first && stop_kind == TERM_NOT_SEARCHED) begin
        if (w == TERM_STOP) begin
          view.stop_kind       = TERM_IS_STOP;
          view.stop_word_index = idx[STOP_IDX_W-1:0];
        end else if (w == TERM_CRCSTOP) begin
          view.stop_kind       = TERM_IS_CRCSTOP;
          view.stop_word_index = idx[STOP_IDX_W-1:0];
        end
      end
    end
  end

  // Commit the folded state, or clear it once the last word has passed.
  always_ff @(posedge clk) begin
    if (rst || (advance && item.last)) begin
      word_index       <= '0;
      running_sum      <= '0;
      preamble_seen_ok <= 1'b0;
      load_code        <= LOAD_BAD;
      checksum_result  <= CK_NOT_CHECKED;
      stop_kind        <= TERM_NOT_SEARCHED;
      stop_word_index  <= '0;
      live_mismatch    <= 1'b0;
    end else if (advance) begin
      word_index       <= view.word_count;
      running_sum      <= view.running_sum;
      preamble_seen_ok <= view.preamble_ok;
      load_code        <= view.load_code;
      checksum_result  <= view.checksum_result;
      stop_kind        <= view.stop_kind;
      stop_word_index  <= view.stop_word_index;
      live_mismatch    <= view.live_mismatch;
    end
  end

endmodule

FILE: rtl/bihc_verdict.sv
// Verdict logic of the boot image header checker: turns the final stream
// state into the result fields. Purely combinational.
// Depends on bihc_pkg.
module bihc_verdict
  import bihc_pkg::*;
(
  input  track_t    view,
  input  logic      live_enable,
  output out_item_t verdict
);

  logic [WORD_IDX_W-1:0] n;
  logic [LEN_W-1:0]      slot_len;
  logic [STOP_IDX_W-1:0] scan_first;
  logic [TERM_OFF_W-1:0] toff;
  logic [STOP_IDX_W-1:0] cmd_words;

  assign n          = view.word_count;
  assign slot_len   = {n, 2'b00};
  assign scan_first = (view.load_code == LOAD_WITH) ? STOP_IDX_W'(CFG_END_WORD + 1)
                                                    : STOP_IDX_W'(CFG_END_WORD);
  assign toff       = {view.stop_word_index, 2'b00};
  assign cmd_words  = view.stop_word_index - scan_first;

  // Build the result, failure checks first, then the terminator summary.
  always_comb begin
    verdict                 = '0;
    verdict.image_length    = slot_len;
    if (n < WORD_IDX_W'(2)) begin
      verdict.slot_too_short = 1'b1;
      verdict.check_failed   = 1'b1;
    end else begin
      verdict.preamble_ok = view.preamble_ok;
      verdict.load_kind   = view.load_code;
      if (!view.preamble_ok || view.load_code == LOAD_BAD) begin
        verdict.check_failed = 1'b1;
      end
      if (n < WORD_IDX_W'(CFG_END_WORD)) begin
        verdict.check_failed = 1'b1;
      end else begin
        verdict.config_present = 1'b1;
        verdict.computed_sum   = view.running_sum;
        if (view.load_code == LOAD_WITH && n >= WORD_IDX_W'(CFG_END_WORD + 1)) begin
          verdict.checksum_status = view.checksum_result;
          if (view.checksum_result == CK_FAIL) begin
            verdict.check_failed = 1'b1;
          end
        end else if (view.load_code == LOAD_NO_SUM) begin
          verdict.checksum_status = CK_SKIPPED;
        end
        if (view.stop_kind != TERM_NOT_SEARCHED) begin
          verdict.terminator_kind   = view.stop_kind;
          verdict.terminator_offset = toff;
          if ({1'b0, view.stop_word_index} + WORD_IDX_W'(2) <= n) begin
            verdict.image_length = {1'b0, toff} + LEN_W'(8);
          end
          if (view.stop_word_index > scan_first) begin
            verdict.command_bytes = {1'b0, cmd_words, 2'b00};
          end
        end else begin
          verdict.terminator_kind = TERM_NONE_FOUND;
        end
        if (live_enable) begin
          verdict.live_match = view.live_mismatch ? LIVE_DIFFER : LIVE_EQUAL;
        end
      end
    end
  end

endmodule

FILE: rtl/boot_image_header_checker.sv
// Boot image header checker, top level.
// A result is captured in the result register once the last word has passed the input register.
// Throughput: one word per cycle, limited only by the result register stall.
// Reset: synchronous rst clears the stream state, both valid flags and the
// live compare enable; no clearing pass is needed.
// Depends on bihc_pkg, bihc_track and bihc_verdict.
module boot_image_header_checker
  import bihc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      live_compare_enable;
  logic      s1_valid;
  in_item_t  s1_data;
  logic      s1_go;
  logic      out_free;
  track_t    view;
  out_item_t verdict;

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_compare_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      live_compare_enable <= cfg_data;
    end
  end

  // Flow control: a non-last word never needs the result register.
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1_data.last || out_free);
  assign in_stall = s1_valid && !s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Stream state and verdict.
  bihc_track u_track (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_go),
    .item        (s1_data),
    .live_enable (live_compare_enable),
    .view        (view)
  );

  bihc_verdict u_verdict (
    .view        (view),
    .live_enable (live_compare_enable),
    .verdict     (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && s1_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_data.last) begin
      out_data <= verdict;
    end
  end

  // A last word that moves on always leaves a result behind it.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_data.last |=> out_valid)
    else $error("last word did not produce a result");

  // Only a last word waiting on a full result register holds off input.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_data.last && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A short slot is always a failure.
  a_short_fails: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.slot_too_short |-> out_data.check_failed)
    else $error("short slot reported without failure");

  // Missing configuration words mean failure and no terminator search.
  a_trunc_fails: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.config_present |->
      out_data.check_failed && out_data.terminator_kind == TERM_NOT_SEARCHED)
    else $error("truncated header reported inconsistently");

endmodule

FILE: sim/boot_image_header_checker_tb.sv
// Self-checking testbench for boot_image_header_checker: streams boot images word by word,
// predicts each slot verdict in a behavioral copy of the header checks and compares results.
// Depends on bihc_pkg and the boot_image_header_checker RTL.
module boot_image_header_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bihc_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_GAP         = 6;
  localparam int RANDOM_WORDS    = 300;
  localparam int RANDOM_VERDICTS = 12;
  localparam int HOLD_CYCLES     = 300;

  // Predicted stream state, mirrors what the block keeps between words.
  typedef struct packed {
    logic [WORD_IDX_W-1:0] count;
    logic [31:0]           sum;
    logic                  pre_ok;
    load_kind_t            load;
    cksum_status_t         cksum;
    term_kind_t            term;
    logic [STOP_IDX_W-1:0] term_idx;
    logic                  mismatch;
  } stream_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  stream_t     strm;
  logic        live_en;
  out_item_t   verdict_q[$];
  logic [31:0] img_q[$];
  logic [31:0] live_q[$];

  int errors        = 0;
  int words_sent    = 0;
  int verdicts_seen = 0;
  int cycle_count   = 0;
  int rx_hold       = 0;
  bit tx_fast       = 1'b0;
  bit rx_eager      = 1'b0;

  boot_image_header_checker u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  function automatic stream_t stream_clear();
    stream_t s;
    s.count    = '0;
    s.sum      = '0;
    s.pre_ok   = 1'b0;
    s.load     = LOAD_BAD;
    s.cksum    = CK_NOT_CHECKED;
    s.term     = TERM_NOT_SEARCHED;
    s.term_idx = '0;
    s.mismatch = 1'b0;
    return s;
  endfunction

  // Fold one accepted word into the predicted state; on the last word queue the verdict.
  task automatic predict_word(input in_item_t it);
    int        idx;
    int        scan_from;
    int        n;
    int        ilen;
    int        toff;
    int        tidx;
    out_item_t v;
    if (strm.count < SLOT_WORDS) begin
      idx = strm.count;
      scan_from = (strm.load == LOAD_WITH) ? CFG_END_WORD + 1 : CFG_END_WORD;
      if (idx < CFG_END_WORD) strm.sum = strm.sum + it.slot_word;
      if (idx == 0) strm.pre_ok = (it.slot_word == PREAMBLE_WORD);
      if (idx == 1) begin
        if (it.slot_word == LOAD_CKSUM) strm.load = LOAD_WITH;
        else if (it.slot_word == LOAD_NOCKSUM) strm.load = LOAD_NO_SUM;
        else strm.load = LOAD_BAD;
      end
      if (idx >= 2 && idx < CFG_END_WORD && live_en && it.slot_word != it.live_word)
        strm.mismatch = 1'b1;
      if (idx == CFG_END_WORD && strm.load == LOAD_WITH)
        strm.cksum = (strm.sum == it.slot_word) ? CK_PASS : CK_FAIL;
      if (idx >= scan_from && strm.term == TERM_NOT_SEARCHED) begin
        if (it.slot_word == TERM_STOP) begin
          strm.term     = TERM_IS_STOP;
          strm.term_idx = STOP_IDX_W'(idx);
        end else if (it.slot_word == TERM_CRCSTOP) begin
          strm.term     = TERM_IS_CRCSTOP;
          strm.term_idx = STOP_IDX_W'(idx);
        end
      end
      strm.count = strm.count + 1'b1;
    end
    if (!it.last) return;

    // Build the verdict for the finished slot.
    n    = strm.count;
    ilen = n * 4;
    v    = '0;
    if (n < 2) begin
      v.slot_too_short = 1'b1;
      v.check_failed   = 1'b1;
    end else begin
      v.preamble_ok = strm.pre_ok;
      v.load_kind   = strm.load;
      if (!strm.pre_ok || strm.load == LOAD_BAD) v.check_failed = 1'b1;
      if (n < CFG_END_WORD) begin
        v.check_failed = 1'b1;
      end else begin
        v.config_present = 1'b1;
        v.computed_sum   = strm.sum;
        if (strm.load == LOAD_WITH && n >= CFG_END_WORD + 1) begin
          v.checksum_status = strm.cksum;
          if (strm.cksum == CK_FAIL) v.check_failed = 1'b1;
        end else if (strm.load == LOAD_NO_SUM) begin
          v.checksum_status = CK_SKIPPED;
        end
        scan_from = (strm.load == LOAD_WITH) ? CFG_END_WORD + 1 : CFG_END_WORD;
        if (strm.term != TERM_NOT_SEARCHED) begin
          tidx = strm.term_idx;
          toff = tidx * 4;
          v.terminator_kind   = strm.term;
          v.terminator_offset = TERM_OFF_W'(toff);
          if (tidx + 2 <= n) ilen = toff + 8;
          if (tidx > scan_from) v.command_bytes = LEN_W'((tidx - scan_from) * 4);
        end else begin
          v.terminator_kind = TERM_NONE_FOUND;
        end
        if (live_en) v.live_match = strm.mismatch ? LIVE_DIFFER : LIVE_EQUAL;
      end
    end
    v.image_length = LEN_W'(ilen);
    verdict_q.push_back(v);
    strm = stream_clear();
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Compare every result transfer with the oldest predicted verdict.
  always @(posedge clk) begin : verdict_checker
    out_item_t exp_v;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        check_field("slot_too_short", exp_v.slot_too_short, out_data.slot_too_short);
        check_field("preamble_ok", exp_v.preamble_ok, out_data.preamble_ok);
        check_field("load_kind", exp_v.load_kind, out_data.load_kind);
        check_field("config_present", exp_v.config_present, out_data.config_present);
        check_field("checksum_status", exp_v.checksum_status, out_data.checksum_status);
        check_field("computed_sum", exp_v.computed_sum, out_data.computed_sum);
        check_field("terminator_kind", exp_v.terminator_kind, out_data.terminator_kind);
        check_field("terminator_offset", exp_v.terminator_offset, out_data.terminator_offset);
        check_field("image_length", exp_v.image_length, out_data.image_length);
        check_field("command_bytes", exp_v.command_bytes, out_data.command_bytes);
        check_field("live_match", exp_v.live_match, out_data.live_match);
        check_field("check_failed", exp_v.check_failed, out_data.check_failed);
      end
    end
  end

  // Result side: random stall before each transfer, plus an optional long hold-off.
  initial begin : result_receiver
    int wait_n;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end else begin
        wait_n = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0) && rx_hold == 0);
      @(negedge clk);
    end
  end

  // Offer one word after a random gap and hold it until the transfer happens.
  // Entered and left at a falling edge; valid stays high so back-to-back words need no gap.
  task automatic send_word(input logic [31:0] word, input logic [31:0] live,
                           input logic is_last);
    int       gap;
    bit       taken;
    in_item_t it;
    gap          = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    it.slot_word = word;
    it.live_word = live;
    it.last      = is_last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (in_stall === 1'b0);
      if (taken) begin
        predict_word(it);
        words_sent++;
      end
      @(negedge clk);
    end
  endtask

  task automatic send_range(input int first, input int count);
    for (int i = first; i < first + count; i++)
      send_word(img_q[i], live_q[i], i == img_q.size() - 1);
  endtask

  task automatic send_image();
    send_range(0, img_q.size());
  endtask

  // Stop offering words and wait until every predicted verdict has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_live_enable(input logic value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    live_en = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Image with a good preamble, the given command word and random body.
  // Live words mirror the image words.
  task automatic make_image(input logic [31:0] load_w, input int n);
    logic [31:0] w;
    img_q.delete();
    live_q.delete();
    for (int i = 0; i < n; i++) begin
      if (i == 0) w = PREAMBLE_WORD;
      else if (i == 1) w = load_w;
      else w = $urandom;
      img_q.push_back(w);
      live_q.push_back(w);
    end
  endtask

  // Put the correct wrapping sum of the header words into the checksum word.
  task automatic fix_checksum();
    logic [31:0] s;
    s = '0;
    if (img_q.size() > CFG_END_WORD) begin
      for (int i = 0; i < CFG_END_WORD; i++) s = s + img_q[i];
      img_q[CFG_END_WORD] = s;
    end
  endtask

  task automatic random_image();
    int          sel;
    int          n;
    int          pos;
    int          tk;
    logic [31:0] load_w;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      // Noise: random words of random length.
      n = $urandom_range(1, 48);
      img_q.delete();
      live_q.delete();
      repeat (n) begin
        img_q.push_back($urandom);
        live_q.push_back($urandom);
      end
      if (n > 1 && $urandom_range(0, 1) == 1) img_q[0] = PREAMBLE_WORD;
    end else begin
      case ($urandom_range(0, 9))
        0:             load_w = $urandom;
        1, 2, 3, 4, 5: load_w = LOAD_CKSUM;
        default:       load_w = LOAD_NOCKSUM;
      endcase
      n = (sel < 3) ? $urandom_range(1, CFG_END_WORD + 1)
                    : $urandom_range(CFG_END_WORD, CFG_END_WORD + 16);
      make_image(load_w, n);
      // A terminator pattern inside the configuration area must be ignored.
      if ($urandom_range(0, 5) == 0) begin
        pos = $urandom_range(2, CFG_END_WORD - 1);
        if (pos < n) begin
          img_q[pos]  = ($urandom_range(0, 1) == 1) ? TERM_STOP : TERM_CRCSTOP;
          live_q[pos] = img_q[pos];
        end
      end
      tk = $urandom_range(0, 3);
      if (tk != 0) begin
        pos = $urandom_range(CFG_END_WORD - 1, n + 1);
        if (pos < n) img_q[pos] = (tk == 1) ? TERM_STOP : TERM_CRCSTOP;
        if (tk == 3 && pos + 1 < n) img_q[pos + 1] = TERM_STOP;
      end
      if ($urandom_range(0, 4) != 0) fix_checksum();
      if ($urandom_range(0, 15) == 0)
        img_q[0] = img_q[0] ^ (32'h1 << $urandom_range(0, 31));
      if (n > 2 && $urandom_range(0, 3) == 0) begin
        pos = $urandom_range(2, n - 1);
        live_q[pos] = live_q[pos] ^ ($urandom | 32'h1);
      end
    end
  endtask

  // Enable is still at its reset value, so live words are never compared.
  task automatic test_reset_default();
    make_image(LOAD_CKSUM, 40);
    fix_checksum();
    img_q[37] = TERM_STOP;
    live_q[5] = ~live_q[5];
    send_image();
  endtask

  // Slots too short for the header, truncated configuration, missing checksum word.
  task automatic test_short_slots();
    make_image(LOAD_CKSUM, 1);
    send_image();
    make_image(LOAD_NOCKSUM, 2);
    send_image();
    make_image(LOAD_CKSUM, CFG_END_WORD - 1);
    send_image();
    make_image(LOAD_CKSUM, CFG_END_WORD);
    send_image();
    make_image(LOAD_NOCKSUM, CFG_END_WORD);
    send_image();
    make_image(LOAD_NOCKSUM, CFG_END_WORD + 1);
    img_q[CFG_END_WORD] = TERM_CRCSTOP;
    send_image();
  endtask

  // Every load command, checksum pass and fail, bad preamble, sum wraparound.
  task automatic test_load_kinds();
    make_image(LOAD_CKSUM, 40);
    img_q[CFG_END_WORD + 1] = TERM_STOP;
    fix_checksum();
    send_image();
    make_image(LOAD_CKSUM, 40);
    fix_checksum();
    img_q[CFG_END_WORD] = img_q[CFG_END_WORD] ^ 32'h1;
    send_image();
    make_image(LOAD_NOCKSUM, 40);
    img_q[36] = TERM_STOP;
    send_image();
    make_image(32'hFFFF_FFFF, 36);
    send_image();
    make_image(32'h0000_0000, 36);
    send_image();
    make_image(LOAD_CKSUM | 32'h1, 36);
    send_image();
    make_image(LOAD_CKSUM, 36);
    img_q[0] = 32'h0000_0000;
    fix_checksum();
    send_image();
    // All-ones configuration words make the sum wrap.
    make_image(LOAD_CKSUM, 36);
    for (int i = 2; i < CFG_END_WORD; i++) begin
      img_q[i]  = 32'hFFFF_FFFF;
      live_q[i] = 32'hFFFF_FFFF;
    end
    fix_checksum();
    send_image();
  endtask

  // First terminator wins, scan start depends on the command, terminator as last word.
  task automatic test_terminators();
    make_image(LOAD_NOCKSUM, 50);
    img_q[10]           = TERM_CRCSTOP;
    live_q[10]          = TERM_CRCSTOP;
    img_q[CFG_END_WORD] = TERM_STOP;
    img_q[40]           = TERM_CRCSTOP;
    send_image();
    make_image(LOAD_CKSUM, 50);
    img_q[20]  = TERM_STOP;
    live_q[20] = TERM_STOP;
    img_q[48]  = TERM_CRCSTOP;
    img_q[49]  = TERM_STOP;
    fix_checksum();
    send_image();
    make_image(LOAD_CKSUM, 60);
    img_q[59] = TERM_STOP;
    fix_checksum();
    send_image();
    make_image(LOAD_CKSUM, 60);
    fix_checksum();
    send_image();
    // A stop pattern in the checksum word fails the checksum and is not scanned.
    make_image(LOAD_CKSUM, 40);
    img_q[CFG_END_WORD] = TERM_STOP;
    send_image();
  endtask

  // Live comparison on and off, range of compared words, enable flipped mid-slot.
  task automatic test_live_compare();
    write_live_enable(1'b1);
    make_image(LOAD_NOCKSUM, 40);
    live_q[1]            = ~live_q[1];
    live_q[CFG_END_WORD] = ~live_q[CFG_END_WORD];
    send_image();
    make_image(LOAD_NOCKSUM, 40);
    live_q[2] = live_q[2] ^ 32'h8000_0000;
    send_image();
    make_image(LOAD_CKSUM, 40);
    fix_checksum();
    live_q[CFG_END_WORD - 1] = live_q[CFG_END_WORD - 1] ^ 32'h1;
    send_image();
    make_image(LOAD_CKSUM, 20);
    live_q[4] = ~live_q[4];
    send_image();
    // Mismatch arrives while disabled, then the enable is raised mid-slot.
    write_live_enable(1'b0);
    make_image(LOAD_CKSUM, 40);
    fix_checksum();
    live_q[5] = ~live_q[5];
    send_range(0, 10);
    write_live_enable(1'b1);
    send_range(10, 30);
    // Enable dropped before the last word.
    make_image(LOAD_CKSUM, 40);
    fix_checksum();
    live_q[20] = ~live_q[20];
    send_range(0, 25);
    write_live_enable(1'b0);
    send_range(25, 15);
    // Mismatch after the enable is raised mid-slot.
    make_image(LOAD_NOCKSUM, 40);
    live_q[30] = ~live_q[30];
    send_range(0, 20);
    write_live_enable(1'b1);
    send_range(20, 20);
  endtask

  // A slot beyond the slot size, with its first terminator on the last word that counts.
  task automatic test_overlong();
    tx_fast = 1'b1;
    make_image(LOAD_CKSUM, SLOT_WORDS + 4);
    fix_checksum();
    img_q[SLOT_WORDS - 1] = TERM_CRCSTOP;
    img_q[SLOT_WORDS + 1] = TERM_STOP;
    send_image();
    tx_fast = 1'b0;
  endtask

  // Receiver holds off while short slots keep coming, so the block must stall its input.
  task automatic test_backpressure();
    wait_idle();
    rx_hold = HOLD_CYCLES;
    tx_fast = 1'b1;
    repeat (30) begin
      make_image(($urandom_range(0, 1) == 1) ? LOAD_CKSUM : LOAD_NOCKSUM,
                 $urandom_range(1, 3));
      send_image();
    end
    tx_fast = 1'b0;
    wait_idle();
  endtask

  // Random slots in phases, with the enable rewritten between phases.
  task automatic test_random();
    int words_at;
    int verdicts_at;
    words_at    = words_sent;
    verdicts_at = verdicts_seen;
    while (words_sent < words_at + RANDOM_WORDS ||
           verdicts_seen < verdicts_at + RANDOM_VERDICTS) begin
      tx_fast  = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      repeat (6) begin
        random_image();
        send_image();
      end
      write_live_enable($urandom_range(0, 1));
    end
    tx_fast  = 1'b0;
    rx_eager = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    strm      = stream_clear();
    live_en   = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_short_slots();
    test_load_kinds();
    test_terminators();
    test_live_compare();
    write_live_enable(1'b0);
    test_overlong();
    test_backpressure();
    test_random();

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: boot_image_header_checker.f
rtl/bihc_pkg.sv
rtl/bihc_track.sv
rtl/bihc_verdict.sv
rtl/boot_image_header_checker.sv
sim/boot_image_header_checker_tb.sv
